// ----- hw/rtl/porct_pkg.sv -----
// ----------------------------------------------------------------------------
// porct_pkg
// Shared widths, payload structs, microcode and controller command types for
// the origin-relative pose transform.
// ----------------------------------------------------------------------------
package porct_pkg;

   localparam int POS_W  = 32;
   localparam int ROT_W  = 16;
   localparam int DIFF_W = POS_W + 1;
   localparam int T_W    = 40;
   localparam int R_W    = 26;
   localparam int NORM_W = 52;
   localparam int S_W    = NORM_W / 2;
   localparam int A_W    = 27;
   localparam int B_W    = 40;
   localparam int P_W    = A_W + B_W;
   localparam int ACC_W  = P_W + 1;

   localparam int MAC_STEPS  = 36;
   localparam int STEP_W     = 6;
   localparam int SQRT_STEPS = S_W;
   localparam int DIV_STEPS  = ROT_W - 1;
   localparam int CNT_W      = 5;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [ROT_W-1:0] rot_x;
      logic signed [ROT_W-1:0] rot_y;
      logic signed [ROT_W-1:0] rot_z;
      logic signed [ROT_W-1:0] rot_w;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] out_pos_x;
      logic signed [POS_W-1:0] out_pos_y;
      logic signed [POS_W-1:0] out_pos_z;
      logic signed [ROT_W-1:0] out_rot_x;
      logic signed [ROT_W-1:0] out_rot_y;
      logic signed [ROT_W-1:0] out_rot_z;
      logic signed [ROT_W-1:0] out_rot_w;
   } rsp_type;

   typedef enum logic [2:0] {
      A_UX, A_UY, A_UZ, A_UW, A_R0, A_R1, A_R2, A_R3
   } a_src_type;

   typedef enum logic [3:0] {
      B_D0, B_D1, B_D2, B_T0, B_T1, B_T2,
      B_Q0, B_Q1, B_Q2, B_Q3, B_R0, B_R1, B_R2, B_R3
   } b_src_type;

   typedef enum logic [3:0] {
      DST_T0, DST_T1, DST_T2, DST_P0, DST_P1, DST_P2,
      DST_R0, DST_R1, DST_R2, DST_R3, DST_N
   } dst_type;

   typedef struct packed {
      logic      valid;
      a_src_type a_src;
      b_src_type b_src;
      logic      neg;
      logic      first;
      logic      last;
      dst_type   dst;
   } uop_type;

   typedef struct packed {
      logic             load_item;
      logic             latch_origin;
      logic             calc_diff;
      uop_type          uop;
      logic             sqrt_load;
      logic             sqrt_step;
      logic             div_load;
      logic             div_step;
      logic             div_store;
      logic [1:0]       div_idx;
      logic             out_load;
      logic             out_pass;
   } cmd_type;

   localparam uop_type UOP_NOP = '{valid: 1'b0, a_src: A_UX, b_src: B_D0, neg: 1'b0,
                                   first: 1'b0, last: 1'b0, dst: DST_T0};

   function automatic uop_type mk_uop(input a_src_type a, input b_src_type b,
                                      input logic neg, input logic first,
                                      input logic last, input dst_type dst);
      uop_type u;
      u = '{valid: 1'b1, a_src: a, b_src: b, neg: neg, first: first, last: last,
            dst: dst};
      return u;
   endfunction

   // multiply-accumulate program: cross products, rotation, hamilton, norm
   function automatic uop_type uop_at(input logic [STEP_W-1:0] step);
      uop_type u;
      u = UOP_NOP;
      case (step)
         6'd0:  u = mk_uop(A_UY, B_D2, 1'b0, 1'b1, 1'b0, DST_T0);
         6'd1:  u = mk_uop(A_UZ, B_D1, 1'b1, 1'b0, 1'b1, DST_T0);
         6'd2:  u = mk_uop(A_UZ, B_D0, 1'b0, 1'b1, 1'b0, DST_T1);
         6'd3:  u = mk_uop(A_UX, B_D2, 1'b1, 1'b0, 1'b1, DST_T1);
         6'd4:  u = mk_uop(A_UX, B_D1, 1'b0, 1'b1, 1'b0, DST_T2);
         6'd5:  u = mk_uop(A_UY, B_D0, 1'b1, 1'b0, 1'b1, DST_T2);
         6'd7:  u = mk_uop(A_UW, B_T0, 1'b0, 1'b1, 1'b0, DST_P0);
         6'd8:  u = mk_uop(A_UY, B_T2, 1'b0, 1'b0, 1'b0, DST_P0);
         6'd9:  u = mk_uop(A_UZ, B_T1, 1'b1, 1'b0, 1'b1, DST_P0);
         6'd10: u = mk_uop(A_UW, B_T1, 1'b0, 1'b1, 1'b0, DST_P1);
         6'd11: u = mk_uop(A_UZ, B_T0, 1'b0, 1'b0, 1'b0, DST_P1);
         6'd12: u = mk_uop(A_UX, B_T2, 1'b1, 1'b0, 1'b1, DST_P1);
         6'd13: u = mk_uop(A_UW, B_T2, 1'b0, 1'b1, 1'b0, DST_P2);
         6'd14: u = mk_uop(A_UX, B_T1, 1'b0, 1'b0, 1'b0, DST_P2);
         6'd15: u = mk_uop(A_UY, B_T0, 1'b1, 1'b0, 1'b1, DST_P2);
         6'd16: u = mk_uop(A_UW, B_Q3, 1'b0, 1'b1, 1'b0, DST_R3);
         6'd17: u = mk_uop(A_UX, B_Q0, 1'b1, 1'b0, 1'b0, DST_R3);
         6'd18: u = mk_uop(A_UY, B_Q1, 1'b1, 1'b0, 1'b0, DST_R3);
         6'd19: u = mk_uop(A_UZ, B_Q2, 1'b1, 1'b0, 1'b1, DST_R3);
         6'd20: u = mk_uop(A_UW, B_Q0, 1'b0, 1'b1, 1'b0, DST_R0);
         6'd21: u = mk_uop(A_UX, B_Q3, 1'b0, 1'b0, 1'b0, DST_R0);
         6'd22: u = mk_uop(A_UY, B_Q2, 1'b0, 1'b0, 1'b0, DST_R0);
         6'd23: u = mk_uop(A_UZ, B_Q1, 1'b1, 1'b0, 1'b1, DST_R0);
         6'd24: u = mk_uop(A_UW, B_Q1, 1'b0, 1'b1, 1'b0, DST_R1);
         6'd25: u = mk_uop(A_UX, B_Q2, 1'b1, 1'b0, 1'b0, DST_R1);
         6'd26: u = mk_uop(A_UY, B_Q3, 1'b0, 1'b0, 1'b0, DST_R1);
         6'd27: u = mk_uop(A_UZ, B_Q0, 1'b0, 1'b0, 1'b1, DST_R1);
         6'd28: u = mk_uop(A_UW, B_Q2, 1'b0, 1'b1, 1'b0, DST_R2);
         6'd29: u = mk_uop(A_UX, B_Q1, 1'b0, 1'b0, 1'b0, DST_R2);
         6'd30: u = mk_uop(A_UY, B_Q0, 1'b1, 1'b0, 1'b0, DST_R2);
         6'd31: u = mk_uop(A_UZ, B_Q3, 1'b0, 1'b0, 1'b1, DST_R2);
         6'd32: u = mk_uop(A_R0, B_R0, 1'b0, 1'b1, 1'b0, DST_N);
         6'd33: u = mk_uop(A_R1, B_R1, 1'b0, 1'b0, 1'b0, DST_N);
         6'd34: u = mk_uop(A_R2, B_R2, 1'b0, 1'b0, 1'b0, DST_N);
         6'd35: u = mk_uop(A_R3, B_R3, 1'b0, 1'b0, 1'b1, DST_N);
         default: u = UOP_NOP;
      endcase
      return u;
   endfunction

endpackage

// ----- hw/rtl/porct_dp.sv -----
// ----------------------------------------------------------------------------
// porct_dp
// Datapath: origin store, shared multiply-accumulate, bit-serial square root,
// restoring divider and result register.
// ----------------------------------------------------------------------------
module porct_dp (
   input  logic               clock,
   input  logic               reset,
   input  porct_pkg::cmd_type cmd,
   input  porct_pkg::req_type req_data,
   output porct_pkg::rsp_type rsp_data
);
   import porct_pkg::*;

   req_type                  item_ff;
   logic signed [POS_W-1:0]  org_pos_ff [3];
   logic signed [ROT_W-1:0]  inv_ff [4];
   logic signed [DIFF_W-1:0] d_ff [3];
   logic signed [T_W-1:0]    t_ff [3];
   logic signed [R_W-1:0]    r_ff [4];
   logic [NORM_W-1:0]        norm_ff;
   logic signed [POS_W-1:0]  pos_res_ff [3];
   logic signed [ROT_W-1:0]  rot_res_ff [4];
   rsp_type                  rsp_ff;

   logic signed [A_W-1:0]    mul_a;
   logic signed [B_W-1:0]    mul_b;
   logic signed [P_W-1:0]    prod_ff;
   uop_type                  p_uop_ff;
   logic                     p_valid_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  init_val;
   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-15:0] pos_wide;
   logic signed [POS_W-1:0]  pos_sat;

   logic [NORM_W-1:0]        sq_n_ff;
   logic [S_W+1:0]           sq_rem_ff;
   logic [S_W-1:0]           sq_root_ff;
   logic [S_W+3:0]           sq_rem_sh;
   logic [S_W+3:0]           sq_trial;
   logic                     sq_ge;

   logic [S_W-1:0]           dv_rem_ff;
   logic [DIV_STEPS-1:0]     dv_quo_ff;
   logic                     dv_neg_ff;
   logic signed [R_W-1:0]    dv_r;
   logic [R_W-1:0]           dv_mag;
   logic [S_W+DIV_STEPS-1:0] dv_num;
   logic [S_W:0]             dv_rem_sh;
   logic                     dv_ge;
   logic [DIV_STEPS-1:0]     dv_clamp;
   logic [ROT_W-1:0]         dv_val;

   localparam logic [DIV_STEPS-1:0] ROT_ONE = DIV_STEPS'(16384);
   localparam logic signed [ROT_W-1:0] ROT_MIN = {1'b1, {(ROT_W-1){1'b0}}};
   localparam logic signed [ROT_W-1:0] ROT_MAX = {1'b0, {(ROT_W-1){1'b1}}};

   function automatic logic signed [ROT_W-1:0] conj(input logic signed [ROT_W-1:0] q);
      return (q == ROT_MIN) ? ROT_MAX : -q;
   endfunction

   // operand select
   always_comb begin
      unique case (cmd.uop.a_src)
         A_UX: mul_a = A_W'(inv_ff[0]);
         A_UY: mul_a = A_W'(inv_ff[1]);
         A_UZ: mul_a = A_W'(inv_ff[2]);
         A_UW: mul_a = A_W'(inv_ff[3]);
         A_R0: mul_a = A_W'(r_ff[0]);
         A_R1: mul_a = A_W'(r_ff[1]);
         A_R2: mul_a = A_W'(r_ff[2]);
         A_R3: mul_a = A_W'(r_ff[3]);
      endcase
      unique case (cmd.uop.b_src)
         B_D0:    mul_b = B_W'(d_ff[0]);
         B_D1:    mul_b = B_W'(d_ff[1]);
         B_D2:    mul_b = B_W'(d_ff[2]);
         B_T0:    mul_b = t_ff[0];
         B_T1:    mul_b = t_ff[1];
         B_T2:    mul_b = t_ff[2];
         B_Q0:    mul_b = B_W'(item_ff.rot_x);
         B_Q1:    mul_b = B_W'(item_ff.rot_y);
         B_Q2:    mul_b = B_W'(item_ff.rot_z);
         B_Q3:    mul_b = B_W'(item_ff.rot_w);
         B_R0:    mul_b = B_W'(r_ff[0]);
         B_R1:    mul_b = B_W'(r_ff[1]);
         B_R2:    mul_b = B_W'(r_ff[2]);
         B_R3:    mul_b = B_W'(r_ff[3]);
         default: mul_b = '0;
      endcase
   end

   // accumulate, rounding constant preloaded on the first term
   always_comb begin
      unique case (p_uop_ff.dst)
         DST_T0, DST_T1, DST_T2: init_val = ACC_W'(4096);
         DST_P0:  init_val = {{(ACC_W-DIFF_W-14){d_ff[0][DIFF_W-1]}}, d_ff[0], 14'h2000};
         DST_P1:  init_val = {{(ACC_W-DIFF_W-14){d_ff[1][DIFF_W-1]}}, d_ff[1], 14'h2000};
         DST_P2:  init_val = {{(ACC_W-DIFF_W-14){d_ff[2][DIFF_W-1]}}, d_ff[2], 14'h2000};
         DST_R0, DST_R1, DST_R2, DST_R3: init_val = ACC_W'(128);
         default: init_val = '0;
      endcase
      base     = p_uop_ff.first ? init_val : acc_ff;
      prod_ext = {prod_ff[P_W-1], prod_ff};
      acc_in   = p_uop_ff.neg ? base - prod_ext : base + prod_ext;
      pos_wide = acc_in[ACC_W-1:14];
      if (pos_wide[ACC_W-15:POS_W-1] == '0 || pos_wide[ACC_W-15:POS_W-1] == '1) begin
         pos_sat = pos_wide[POS_W-1:0];
      end else begin
         pos_sat = {pos_wide[ACC_W-15], {(POS_W-1){~pos_wide[ACC_W-15]}}};
      end
   end

   // square root and divider step logic
   always_comb begin
      sq_rem_sh = {sq_rem_ff, sq_n_ff[NORM_W-1 -: 2]};
      sq_trial  = {2'b00, sq_root_ff, 2'b01};
      sq_ge     = sq_rem_sh >= sq_trial;

      unique case (cmd.div_idx)
         2'd0: dv_r = r_ff[0];
         2'd1: dv_r = r_ff[1];
         2'd2: dv_r = r_ff[2];
         2'd3: dv_r = r_ff[3];
      endcase
      dv_mag    = dv_r[R_W-1] ? R_W'(-dv_r) : R_W'(dv_r);
      dv_num    = (S_W+DIV_STEPS)'({dv_mag, {(DIV_STEPS-1){1'b0}}})
                  + (S_W+DIV_STEPS)'(sq_root_ff >> 1);
      dv_rem_sh = {dv_rem_ff, dv_quo_ff[DIV_STEPS-1]};
      dv_ge     = dv_rem_sh >= {1'b0, sq_root_ff};
      dv_clamp  = (dv_quo_ff > ROT_ONE) ? ROT_ONE : dv_quo_ff;
      if (sq_root_ff == '0) begin
         dv_val = '0;
      end else if (dv_neg_ff) begin
         dv_val = -{1'b0, dv_clamp};
      end else begin
         dv_val = {1'b0, dv_clamp};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= cmd.uop.valid;
      end
      p_uop_ff <= cmd.uop;
      prod_ff  <= mul_a * mul_b;

      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      if (cmd.latch_origin) begin
         org_pos_ff[0] <= req_data.pos_x;
         org_pos_ff[1] <= req_data.pos_y;
         org_pos_ff[2] <= req_data.pos_z;
         inv_ff[0]     <= conj(req_data.rot_x);
         inv_ff[1]     <= conj(req_data.rot_y);
         inv_ff[2]     <= conj(req_data.rot_z);
         inv_ff[3]     <= req_data.rot_w;
      end
      if (cmd.calc_diff) begin
         d_ff[0] <= DIFF_W'(item_ff.pos_x) - DIFF_W'(org_pos_ff[0]);
         d_ff[1] <= DIFF_W'(item_ff.pos_y) - DIFF_W'(org_pos_ff[1]);
         d_ff[2] <= DIFF_W'(item_ff.pos_z) - DIFF_W'(org_pos_ff[2]);
      end

      if (p_valid_ff) begin
         acc_ff <= acc_in;
         if (p_uop_ff.last) begin
            unique case (p_uop_ff.dst)
               DST_T0:  t_ff[0] <= acc_in[T_W+12:13];
               DST_T1:  t_ff[1] <= acc_in[T_W+12:13];
               DST_T2:  t_ff[2] <= acc_in[T_W+12:13];
               DST_P0:  pos_res_ff[0] <= pos_sat;
               DST_P1:  pos_res_ff[1] <= pos_sat;
               DST_P2:  pos_res_ff[2] <= pos_sat;
               DST_R0:  r_ff[0] <= acc_in[R_W+7:8];
               DST_R1:  r_ff[1] <= acc_in[R_W+7:8];
               DST_R2:  r_ff[2] <= acc_in[R_W+7:8];
               DST_R3:  r_ff[3] <= acc_in[R_W+7:8];
               DST_N:   norm_ff <= acc_in[NORM_W-1:0];
               default: norm_ff <= norm_ff;
            endcase
         end
      end

      if (cmd.sqrt_load) begin
         sq_n_ff    <= norm_ff;
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sq_n_ff    <= {sq_n_ff[NORM_W-3:0], 2'b00};
         sq_rem_ff  <= sq_ge ? (S_W+2)'(sq_rem_sh - sq_trial) : sq_rem_sh[S_W+1:0];
         sq_root_ff <= {sq_root_ff[S_W-2:0], sq_ge};
      end

      if (cmd.div_load) begin
         dv_neg_ff <= dv_r[R_W-1];
         dv_rem_ff <= dv_num[S_W+DIV_STEPS-1:DIV_STEPS];
         dv_quo_ff <= dv_num[DIV_STEPS-1:0];
      end else if (cmd.div_step) begin
         dv_rem_ff <= dv_ge ? S_W'(dv_rem_sh - {1'b0, sq_root_ff}) : dv_rem_sh[S_W-1:0];
         dv_quo_ff <= {dv_quo_ff[DIV_STEPS-2:0], dv_ge};
      end
      if (cmd.div_store) begin
         unique case (cmd.div_idx)
            2'd0: rot_res_ff[0] <= dv_val;
            2'd1: rot_res_ff[1] <= dv_val;
            2'd2: rot_res_ff[2] <= dv_val;
            2'd3: rot_res_ff[3] <= dv_val;
         endcase
      end

      if (cmd.out_load) begin
         if (cmd.out_pass) begin
            rsp_ff <= rsp_type'(item_ff);
         end else begin
            rsp_ff.out_pos_x <= pos_res_ff[0];
            rsp_ff.out_pos_y <= pos_res_ff[1];
            rsp_ff.out_pos_z <= pos_res_ff[2];
            rsp_ff.out_rot_x <= rot_res_ff[0];
            rsp_ff.out_rot_y <= rot_res_ff[1];
            rsp_ff.out_rot_z <= rot_res_ff[2];
            rsp_ff.out_rot_w <= rot_res_ff[3];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- hw/rtl/porct_ctrl.sv -----
// ----------------------------------------------------------------------------
// porct_ctrl
// Controller: handshakes, enable register, origin flag and the sequencer that
// steps the datapath through multiply, square root and divide phases.
// ----------------------------------------------------------------------------
module porct_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_wdata,
   output porct_pkg::cmd_type cmd
);
   import porct_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_MAC, ST_DRAIN, ST_SQ_LOAD, ST_SQ_RUN,
      ST_DV_LOAD, ST_DV_RUN, ST_DV_STORE, ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [1:0]        idx_ff;
   logic              enable_ff;
   logic              seen_ff;
   logic              pass_ff;
   logic              rsp_valid_ff;
   logic              accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd              = '0;
      cmd.uop          = (state_ff == ST_MAC) ? uop_at(step_ff) : UOP_NOP;
      cmd.load_item    = accept;
      cmd.latch_origin = accept && !seen_ff;
      cmd.calc_diff    = (state_ff == ST_DIFF);
      cmd.sqrt_load    = (state_ff == ST_SQ_LOAD);
      cmd.sqrt_step    = (state_ff == ST_SQ_RUN);
      cmd.div_load     = (state_ff == ST_DV_LOAD);
      cmd.div_step     = (state_ff == ST_DV_RUN);
      cmd.div_store    = (state_ff == ST_DV_STORE);
      cmd.div_idx      = idx_ff;
      cmd.out_load     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
      cmd.out_pass     = pass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         enable_ff    <= 1'b1;
         seen_ff      <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            enable_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  seen_ff  <= 1'b1;
                  pass_ff  <= !enable_ff;
                  state_ff <= enable_ff ? ST_DIFF : ST_FINISH;
               end
            end
            ST_DIFF: begin
               step_ff  <= '0;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(MAC_STEPS - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_SQ_LOAD;
            end
            ST_SQ_LOAD: begin
               cnt_ff   <= '0;
               state_ff <= ST_SQ_RUN;
            end
            ST_SQ_RUN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
                  idx_ff   <= '0;
                  state_ff <= ST_DV_LOAD;
               end
            end
            ST_DV_LOAD: begin
               cnt_ff   <= '0;
               state_ff <= ST_DV_RUN;
            end
            ST_DV_RUN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_DV_STORE;
               end
            end
            ST_DV_STORE: begin
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= (idx_ff == 2'd3) ? ST_FINISH : ST_DV_LOAD;
            end
            ST_FINISH: begin
               if (cmd.out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_pass_fast: assert property (@(posedge clock) disable iff (reset)
      accept && !enable_ff |=> state_ff == ST_FINISH)
      else $error("pass-through beat did not go straight to finish");
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result load did not raise rsp_valid");
   a_seen_holds: assert property (@(posedge clock) disable iff (reset)
      seen_ff |=> seen_ff)
      else $error("origin flag dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.uop.valid |-> !req_ready && enable_ff == $past(enable_ff) || !cmd.uop.valid)
      else $error("input taken during sequence");
`endif

endmodule

// ----- hw/rtl/pose_origin_relative_transform_core.sv -----
// ----------------------------------------------------------------------------
// pose_origin_relative_transform_core
// Expresses each pose relative to the first pose seen after reset, or passes it through when reorigin_enable is clear.
//
// Usage:
//   req channel (req_valid/req_ready/req_data): one pose per beat.
//   rsp channel (rsp_valid/rsp_ready/rsp_data): one transformed pose per beat.
//   csr channel (csr_valid/csr_ready/csr_wdata): reorigin_enable, always ready;
//   write only while no pose is in flight.
//   With reorigin_enable = 1 a pose runs through 36 passes of the shared
//   multiplier, 26 square root steps and four 15-step divides. One pose is
//   worked on at a time, so a new req beat is taken only after the previous
//   pose has left the sequencer. With reorigin_enable = 0 the pose goes
//   straight to the finish state and is passed through unchanged.
//   Reset clears the origin flag and sets reorigin_enable; the next pose
//   becomes the origin. A finished result sits in the output register while
//   rsp_ready is low; the next pose is accepted and worked on meanwhile, and
//   waits at the end until the output register frees up.
// ----------------------------------------------------------------------------
module pose_origin_relative_transform_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  porct_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output porct_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_wdata
);
   import porct_pkg::*;

   cmd_type cmd;

   porct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   porct_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ----- tb/pose_origin_relative_transform_core_test.sv -----
// ----------------------------------------------------------------------------
// pose_origin_relative_transform_core_test
// Drives poses through the origin-relative transform with random idling on
// both channels, predicts each result in a local model of the block and
// compares every field. Covers origin latching, pass through, saturation and
// zero-norm products across both reorigin_enable settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class pose_scoreboard;
   porct_pkg::rsp_type expected_poses[$];
   int mismatches;
   int checked;
   bit reorigin_on;
   bit origin_valid;
   longint org_pos[3];
   longint inv_rot[4];

   function void clear_origin();
      reorigin_on = 1'b1;
      origin_valid = 1'b0;
      org_pos = '{0, 0, 0};
      inv_rot = '{0, 0, 0, 16384};
   endfunction

   function longint clamp_to(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function longint round_shift(longint v, int s);
      longint y;
      y = v + (longint'(1) <<< (s - 1));
      if (y >= 0) return y >>> s;
      return -((-y + ((longint'(1) <<< s) - 1)) >>> s);
   endfunction

   function longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function void note_pose(porct_pkg::req_type p);
      porct_pkg::rsp_type o;
      longint pp[3], q[4], d[3], c[3], t[3], e[3], r[4], res[3], rq[4];
      longint ux, uy, uz, uw, lim, qv;
      longint unsigned n2, s, mag;
      pp = '{longint'(p.pos_x), longint'(p.pos_y), longint'(p.pos_z)};
      q = '{longint'(p.rot_x), longint'(p.rot_y), longint'(p.rot_z), longint'(p.rot_w)};
      if (!origin_valid) begin
         origin_valid = 1'b1;
         for (int i = 0; i < 3; i++) org_pos[i] = pp[i];
         for (int i = 0; i < 3; i++) inv_rot[i] = clamp_to(-q[i], 16);
         inv_rot[3] = q[3];
      end
      if (!reorigin_on) begin
         o = p;
         expected_poses.push_back(o);
         return;
      end
      ux = inv_rot[0]; uy = inv_rot[1]; uz = inv_rot[2]; uw = inv_rot[3];
      for (int i = 0; i < 3; i++) d[i] = pp[i] - org_pos[i];
      c[0] = uy * d[2] - uz * d[1];
      c[1] = uz * d[0] - ux * d[2];
      c[2] = ux * d[1] - uy * d[0];
      for (int i = 0; i < 3; i++) t[i] = round_shift(c[i], 13);
      e[0] = uy * t[2] - uz * t[1];
      e[1] = uz * t[0] - ux * t[2];
      e[2] = ux * t[1] - uy * t[0];
      for (int i = 0; i < 3; i++)
         res[i] = clamp_to(d[i] + round_shift(uw * t[i] + e[i], 14), 32);
      r[3] = round_shift(uw * q[3] - ux * q[0] - uy * q[1] - uz * q[2], 8);
      r[0] = round_shift(uw * q[0] + ux * q[3] + uy * q[2] - uz * q[1], 8);
      r[1] = round_shift(uw * q[1] - ux * q[2] + uy * q[3] + uz * q[0], 8);
      r[2] = round_shift(uw * q[2] + ux * q[1] - uy * q[0] + uz * q[3], 8);
      n2 = 0;
      for (int i = 0; i < 4; i++) n2 += longint'(r[i] * r[i]);
      s = int_sqrt(n2);
      lim = 16384;
      for (int i = 0; i < 4; i++) begin
         rq[i] = 0;
         if (s != 0) begin
            mag = longint'(r[i] < 0 ? -r[i] : r[i]) << 14;
            qv = (mag + s / 2) / s;
            if (qv > lim) qv = lim;
            rq[i] = r[i] < 0 ? -qv : qv;
         end
      end
      o.out_pos_x = res[0]; o.out_pos_y = res[1]; o.out_pos_z = res[2];
      o.out_rot_x = rq[0]; o.out_rot_y = rq[1]; o.out_rot_z = rq[2]; o.out_rot_w = rq[3];
      expected_poses.push_back(o);
   endfunction

   function void check_pose(porct_pkg::rsp_type got);
      porct_pkg::rsp_type want;
      checked++;
      if (expected_poses.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat %h", got);
         return;
      end
      want = expected_poses.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch pos %0d %0d %0d rot %0d %0d %0d %0d / expected %0d %0d %0d rot %0d %0d %0d %0d",
                     got.out_pos_x, got.out_pos_y, got.out_pos_z, got.out_rot_x,
                     got.out_rot_y, got.out_rot_z, got.out_rot_w,
                     want.out_pos_x, want.out_pos_y, want.out_pos_z, want.out_rot_x,
                     want.out_rot_y, want.out_rot_z, want.out_rot_w);
      end
   endfunction
endclass

module pose_origin_relative_transform_core_test;
   import porct_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_wdata = 1'b0;

   pose_scoreboard board = new();
   bit stim_done = 1'b0;
   int sent;

   pose_origin_relative_transform_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_rot();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return $urandom;
         default: return $urandom_range(0, 32768) - 16384;
      endcase
   endfunction

   function automatic req_type unit_pose(int a);
      req_type p;
      real ang, ax, ay, az, n;
      p.pos_x = rand_pos(); p.pos_y = rand_pos(); p.pos_z = rand_pos();
      ang = ($urandom_range(0, 6283) / 1000.0) + a;
      ax = $urandom_range(0, 2000) - 1000.0;
      ay = $urandom_range(0, 2000) - 1000.0;
      az = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(ax * ax + ay * ay + az * az) + 1.0;
      p.rot_x = $rtoi(16384.0 * $sin(ang / 2) * ax / n);
      p.rot_y = $rtoi(16384.0 * $sin(ang / 2) * ay / n);
      p.rot_z = $rtoi(16384.0 * $sin(ang / 2) * az / n);
      p.rot_w = $rtoi(16384.0 * $cos(ang / 2));
      return p;
   endfunction

   // valid stays high into the next beat when there is no idle gap
   task automatic send_pose(req_type p);
      int idle;
      idle = $urandom_range(0, 3);
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_pose(p);
      sent++;
   endtask

   task automatic write_reorigin(bit v);
      req_valid <= 1'b0;
      while (board.expected_poses.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.reorigin_on = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) board.check_pose(rsp_data);
         rsp_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
      end
   end

   initial begin
      req_type p;
      board.clear_origin();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // origin with extreme rotation components
      p = '{32'sh7fffffff, 32'sh80000000, 32'sd0, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0};
      send_pose(p);
      p = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      send_pose(p);
      p = '0;
      send_pose(p);
      p = '{32'sd0, 32'sd0, 32'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
      send_pose(p);
      p = '{32'sd1, -32'sd1, 32'sd65536, -16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384};
      send_pose(p);
      write_reorigin(1'b0);
      p = '{32'shffffffff, 32'sh0, 32'sh80000000, 16'shffff, 16'sh8000, 16'sh7fff, 16'sh0};
      send_pose(p);
      for (int i = 0; i < 8; i++) send_pose(unit_pose(i));
      write_reorigin(1'b1);
      for (int i = 0; i < 8; i++) send_pose(unit_pose(i));
      for (int ph = 0; ph < 8; ph++) begin
         write_reorigin(ph % 3 != 0);
         for (int i = 0; i < 235; i++) begin
            if ($urandom_range(0, 9) < 8) begin
               send_pose(unit_pose(i));
            end else begin
               p = {rand_pos(), rand_pos(), rand_pos(), rand_rot(), rand_rot(),
                    rand_rot(), rand_rot()};
               send_pose(p);
            end
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (board.expected_poses.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("%0d poses sent, %0d results checked across both reorigin settings",
               sent, board.checked);
      if (board.mismatches == 0 && board.expected_poses.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end
endmodule

// ----- files.f -----
hw/rtl/porct_pkg.sv
hw/rtl/porct_dp.sv
hw/rtl/porct_ctrl.sv
hw/rtl/pose_origin_relative_transform_core.sv
tb/pose_origin_relative_transform_core_test.sv
